/* rtl/gyro_heading_integrator_assert.svh */
// ----------------------------------------------------------------------------
// Gyro heading integrator assertion macros
// Shorthand for the concurrent checks, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef GYRO_HEADING_INTEGRATOR_ASSERT_SVH
`define GYRO_HEADING_INTEGRATOR_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define GHI_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define GHI_ASSERT_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that must hold in the cycle after its antecedent.
`define GHI_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ghi_pkg.sv */
// ----------------------------------------------------------------------------
// ghi_pkg
// Widths, reset values, codes and handshake structs shared by the gyro
// heading integrator and its serial arithmetic units.
// ----------------------------------------------------------------------------
package ghi_pkg;

  // Fixed point position of the heading.
  localparam int FRAC_BITS = 16;

  // Field widths.
  localparam int OPCODE_W   = 2;
  localparam int SAMPLE_W   = 12;
  localparam int TS_W       = 32;
  localparam int HEAD_W     = 25;
  localparam int HEAD_X_W   = HEAD_W + 1;
  localparam int BIAS_W     = 16;
  localparam int DZ_W       = 16;
  localparam int SCALE_W    = 16;
  localparam int CALN_W     = 15;
  localparam int CALSUM_W   = 27;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Arithmetic widths: rate magnitude, product, divisor (scale times 16).
  localparam int MAG_W       = 16;
  localparam int DA_W        = MAG_W + 1;
  localparam int PROD_W      = MAG_W + TS_W;
  localparam int DEN_W       = SCALE_W + 4;
  localparam int MUL_CNT_W   = $clog2(MAG_W);
  localparam int DIV_CNT_W   = $clog2(PROD_W + FRAC_BITS);

  // One full turn, 360 degrees, in heading units.
  localparam logic [HEAD_X_W-1:0] FULL_TURN = HEAD_X_W'(360 << FRAC_BITS);

  // Reset values.
  localparam logic [DZ_W-1:0]    DEADZONE_RESET    = DZ_W'(48);
  localparam logic [SCALE_W-1:0] SCALE_RESET       = SCALE_W'(1330);
  localparam logic [CALN_W-1:0]  CAL_SAMPLES_RESET = CALN_W'(64);
  localparam logic [BIAS_W-1:0]  BIAS_RESET        = BIAS_W'(29917);

  // Item operations.
  typedef enum logic [OPCODE_W-1:0] {
    OP_UPDATE    = 2'd0,
    OP_CAL       = 2'd1,
    OP_SET_ANGLE = 2'd2
  } opcode_t;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DEADZONE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_SAMPLES = 2'd2;

  // Serial multiplier control and status.
  typedef struct packed {
    logic              start;
    logic [MAG_W-1:0]  mag;
    logic [TS_W-1:0]   dt;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  // Serial divider control and status. With frac set the quotient carries
  // FRAC_BITS extra fraction bits and is reduced modulo a full turn.
  typedef struct packed {
    logic              start;
    logic              frac;
    logic [PROD_W-1:0] dividend;
    logic [DEN_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [HEAD_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/ghi_if.sv */
// ----------------------------------------------------------------------------
// ghi_if
// Valid/ready channels of the gyro heading integrator: item requests,
// result requests and configuration writes.
// ----------------------------------------------------------------------------
interface ghi_item_if import ghi_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [SAMPLE_W-1:0] sample;
  logic [TS_W-1:0]     timestamp;
  logic [HEAD_W-1:0]   new_angle;

  modport source (output valid, opcode, sample, timestamp, new_angle, input ready);
  modport sink (input valid, opcode, sample, timestamp, new_angle, output ready);
endinterface

interface ghi_result_if import ghi_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HEAD_W-1:0] heading;
  logic [BIAS_W-1:0] bias_now;
  logic              cal_done;

  modport source (output valid, heading, bias_now, cal_done, input ready);
  modport sink (input valid, heading, bias_now, cal_done, output ready);
endinterface

interface ghi_cfg_if import ghi_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/gyro_heading_integrator.sv */
// ----------------------------------------------------------------------------
// gyro_heading_integrator
// Integrates gyro rate samples into a heading in degrees (9.16 fixed point,
// kept inside one turn), with deadzone, bias calibration and set-angle.
//
//   channel  dir   handshake          payload
//   item     in    valid / ready      opcode, sample, timestamp, new_angle
//   result   out   valid / ready      heading, bias_now, cal_done
//   cfg      in    valid / ready      index, data  (0 deadzone, 1 scale,
//                                                   2 cal_samples)
//
// One item request is in flight at a time and gives exactly one result.
// An update that integrates runs 16 steps of the bit-serial multiplier and
// then 64 steps of the bit-serial divider. A calibration sample that
// completes the average runs 48 divider steps; every other item goes
// straight on to posting its result.
// Reset is synchronous and restores the registers and the heading state.
// The result sits in an output register, so a new item is taken while the
// previous result waits; a stalled result only holds the block at the end
// of the next item. The configuration port is always ready.
// ----------------------------------------------------------------------------
`include "gyro_heading_integrator_assert.svh"

module gyro_heading_integrator import ghi_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  ghi_item_if.sink     item,
  ghi_result_if.source result,
  ghi_cfg_if.sink      cfg
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [DZ_W-1:0]     deadzone;
  logic [SCALE_W-1:0]  scale;
  logic [CALN_W-1:0]   cal_samples;

  // Heading and calibration state.
  logic [HEAD_W-1:0]   heading_reg;
  logic [TS_W-1:0]     last_time;
  logic                time_valid;
  logic [BIAS_W-1:0]   bias;
  logic [CALSUM_W-1:0] cal_sum;
  logic [CALN_W-1:0]   cal_count;

  // Job bookkeeping: whether the divider result is a bias, the rate sign,
  // and whether this item finished a calibration.
  logic                job_cal;
  logic                job_neg;
  logic                done_flag;

  // Output register.
  logic                out_valid;
  logic [HEAD_W-1:0]   out_heading;
  logic [BIAS_W-1:0]   out_bias;
  logic                out_cal_done;

  // Arithmetic unit handshakes.
  mul_req_t            mul_req;
  mul_rsp_t            mul_rsp;
  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                item_take;
  logic [TS_W-1:0]     dt;
  logic [DA_W-1:0]     da;
  logic                da_neg;
  logic [MAG_W-1:0]    mag;
  logic                over_dz;
  logic [SCALE_W-1:0]  scale_eff;
  logic [DEN_W-1:0]    den;
  logic [CALN_W-1:0]   n_eff;
  logic [CALSUM_W-1:0] cal_sum_inc;
  logic [CALN_W-1:0]   cal_count_inc;
  logic                cal_hit;
  logic [HEAD_X_W-1:0] angle_x;
  logic [HEAD_W-1:0]   angle_red;
  logic [HEAD_X_W-1:0] add_sum;
  logic [HEAD_W-1:0]   head_plus;
  logic [HEAD_W-1:0]   head_minus;

  assign item_take = item.valid && item.ready;

  always_comb begin
    // Elapsed time wraps with the millisecond counter.
    dt        = item.timestamp - last_time;
    // Bias-corrected rate in 12.4, and its magnitude.
    da        = {1'b0, item.sample, 4'b0} - {1'b0, bias};
    da_neg    = da[DA_W-1];
    mag       = da_neg ? MAG_W'(-da) : da[MAG_W-1:0];
    over_dz   = mag > deadzone;
    // A zero scale behaves as one; the divisor carries the 12.4 factor.
    scale_eff = (scale == '0) ? SCALE_W'(1) : scale;
    den       = {scale_eff, 4'b0};
    // Calibration bookkeeping; a zero count behaves as one.
    n_eff         = (cal_samples == '0) ? CALN_W'(1) : cal_samples;
    cal_sum_inc   = cal_sum + CALSUM_W'(item.sample);
    cal_count_inc = cal_count + 1'b1;
    cal_hit       = cal_count_inc >= n_eff;
    // A loaded angle is below two turns, so one subtraction wraps it.
    angle_x   = {1'b0, item.new_angle};
    angle_red = (angle_x >= FULL_TURN) ? HEAD_W'(angle_x - FULL_TURN)
                                       : item.new_angle;
    // Apply the signed increment modulo one turn.
    add_sum   = {1'b0, heading_reg} + {1'b0, div_rsp.quotient};
    head_plus = (add_sum >= FULL_TURN) ? HEAD_W'(add_sum - FULL_TURN)
                                       : add_sum[HEAD_W-1:0];
    if (heading_reg >= div_rsp.quotient) begin
      head_minus = heading_reg - div_rsp.quotient;
    end else begin
      head_minus = HEAD_W'({1'b0, heading_reg} + FULL_TURN - {1'b0, div_rsp.quotient});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      deadzone      <= DEADZONE_RESET;
      scale         <= SCALE_RESET;
      cal_samples   <= CAL_SAMPLES_RESET;
      heading_reg   <= '0;
      last_time     <= '0;
      time_valid    <= 1'b0;
      bias          <= BIAS_RESET;
      cal_sum       <= '0;
      cal_count     <= '0;
      out_valid     <= 1'b0;
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;
    end else begin
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;

      // Configuration writes; an index past the list is ignored.
      if (cfg.valid) begin
        case (cfg.index)
          CFG_DEADZONE:    deadzone    <= cfg.data;
          CFG_SCALE:       scale       <= cfg.data;
          CFG_CAL_SAMPLES: cal_samples <= cfg.data[CALN_W-1:0];
          default:         ;
        endcase
      end

      if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item_take) begin
            done_flag <= 1'b0;
            job_cal   <= 1'b0;
            job_neg   <= da_neg;
            state     <= S_DONE;
            case (item.opcode)
              OP_UPDATE: begin
                last_time  <= item.timestamp;
                time_valid <= 1'b1;
                // The first update only latches the time.
                if (time_valid && over_dz) begin
                  mul_req.start <= 1'b1;
                  mul_req.mag   <= mag;
                  mul_req.dt    <= dt;
                  state         <= S_MUL;
                end
              end
              OP_CAL: begin
                if (cal_hit) begin
                  // The mean is sum * 16 / count, taken by the divider.
                  cal_sum          <= '0;
                  cal_count        <= '0;
                  job_cal          <= 1'b1;
                  div_req.start    <= 1'b1;
                  div_req.frac     <= 1'b0;
                  div_req.dividend <= PROD_W'({cal_sum_inc, 4'b0});
                  div_req.divisor  <= DEN_W'(n_eff);
                  state            <= S_DIV;
                end else begin
                  cal_sum   <= cal_sum_inc;
                  cal_count <= cal_count_inc;
                end
              end
              OP_SET_ANGLE: begin
                heading_reg <= angle_red;
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          // The product rate * dt goes on to be divided by 16 * scale.
          if (mul_rsp.done) begin
            div_req.start    <= 1'b1;
            div_req.frac     <= 1'b1;
            div_req.dividend <= mul_rsp.product;
            div_req.divisor  <= den;
            state            <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_rsp.done) begin
            if (job_cal) begin
              bias      <= div_rsp.quotient[BIAS_W-1:0];
              done_flag <= 1'b1;
            end else begin
              heading_reg <= job_neg ? head_minus : head_plus;
            end
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // Wait for the output register to free up, then post the result.
          if (!out_valid || result.ready) begin
            out_valid    <= 1'b1;
            out_heading  <= heading_reg;
            out_bias     <= bias;
            out_cal_done <= done_flag;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign item.ready      = (state == S_IDLE);
  assign cfg.ready       = 1'b1;
  assign result.valid    = out_valid;
  assign result.heading  = out_heading;
  assign result.bias_now = out_bias;
  assign result.cal_done = out_cal_done;

  ghi_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  ghi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  `GHI_ASSERT_ALWAYS(a_heading_range, HEAD_X_W'(heading_reg) < FULL_TURN, "heading outside one turn")
  `GHI_ASSERT_IMPLY(a_mul_owner, mul_rsp.done, state == S_MUL, "multiplier done outside its state")
  `GHI_ASSERT_IMPLY(a_div_owner, div_rsp.done, state == S_DIV, "divider done outside its state")
  `GHI_ASSERT_NEXT(a_one_item, item_take, !item.ready, "second item taken while one is in flight")

endmodule

/* rtl/ghi_mul.sv */
// ----------------------------------------------------------------------------
// ghi_mul
// Bit-serial multiplier: rate magnitude times elapsed time, one magnitude
// bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module ghi_mul import ghi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [MUL_CNT_W-1:0] cnt;
  logic [MAG_W-1:0]     mag_sh;
  logic [TS_W-1:0]      dt;
  logic [PROD_W-1:0]    acc;
  logic [PROD_W-1:0]    acc_next;

  // Shift the partial product and add the time when the magnitude bit is set.
  assign acc_next = {acc[PROD_W-2:0], 1'b0} + (mag_sh[MAG_W-1] ? PROD_W'(dt) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        cnt    <= MUL_CNT_W'(MAG_W - 1);
        mag_sh <= req.mag;
        dt     <= req.dt;
        acc    <= '0;
      end else if (busy) begin
        acc    <= acc_next;
        mag_sh <= {mag_sh[MAG_W-2:0], 1'b0};
        cnt    <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

/* rtl/ghi_div.sv */
// ----------------------------------------------------------------------------
// ghi_div
// Restoring bit-serial divider, one quotient bit per cycle. In fraction
// mode it runs FRAC_BITS extra steps and folds the quotient modulo a full
// turn as the bits arrive; otherwise it keeps the low quotient bits.
// ----------------------------------------------------------------------------
module ghi_div import ghi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic                 frac;
  logic [DIV_CNT_W-1:0] cnt;
  logic [PROD_W-1:0]    dvd;
  logic [DEN_W-1:0]     den;
  logic [DEN_W-1:0]     rem;
  logic [HEAD_W-1:0]    quot;

  logic [DEN_W:0]       rem_sh;
  logic                 q_bit;
  logic [DEN_W-1:0]     rem_next;
  logic [HEAD_X_W-1:0]  q_wide;
  logic [HEAD_W-1:0]    quot_next;

  always_comb begin
    rem_sh   = {rem, dvd[PROD_W-1]};
    q_bit    = rem_sh >= {1'b0, den};
    rem_next = q_bit ? DEN_W'(rem_sh - {1'b0, den}) : rem_sh[DEN_W-1:0];
    q_wide   = {quot, q_bit};
    if (frac && (q_wide >= FULL_TURN)) begin
      quot_next = HEAD_W'(q_wide - FULL_TURN);
    end else begin
      quot_next = q_wide[HEAD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        frac <= req.frac;
        cnt  <= req.frac ? DIV_CNT_W'(PROD_W + FRAC_BITS - 1) : DIV_CNT_W'(PROD_W - 1);
        dvd  <= req.dividend;
        den  <= req.divisor;
        rem  <= '0;
        quot <= '0;
      end else if (busy) begin
        dvd  <= {dvd[PROD_W-2:0], 1'b0};
        rem  <= rem_next;
        quot <= quot_next;
        cnt  <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quot;

endmodule

/* dv/gyro_heading_integrator_tb.sv */
// ----------------------------------------------------------------------------
// gyro_heading_integrator_tb
// Drives item requests and register writes into the gyro heading integrator
// and checks every result request, field by field and in order, against a
// behavioral model of the heading, bias and calibration state kept in this
// bench. A directed table covers the corner cases; random phases follow.
// ----------------------------------------------------------------------------
module gyro_heading_integrator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ghi_pkg::*;

  // Opcode 3 has no operation behind it and register index 3 has no register.
  // Both are still legal on the wire, so they get names of their own here.
  localparam logic [OPCODE_W-1:0]  OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // One full turn in heading units, as a wide number for the model arithmetic.
  localparam longint unsigned TURN = longint'(FULL_TURN);

  localparam int PLAN_LEN     = 28;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 250;

  // What one result request carries.
  typedef struct packed {
    logic [HEAD_W-1:0] heading;
    logic [BIAS_W-1:0] bias;
    logic              done;
  } outcome_t;

  // One row of the directed table: either a register write or an item
  // request. A row marked known carries its own result, typed in by hand;
  // all other rows are checked against the model.
  typedef struct packed {
    logic                  is_reg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [OPCODE_W-1:0]   op;
    logic [SAMPLE_W-1:0]   sample;
    logic [TS_W-1:0]       ts;
    logic [HEAD_W-1:0]     angle;
    logic                  known;
    outcome_t              want;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ghi_item_if   item_bus ();
  ghi_result_if result_bus ();
  ghi_cfg_if    cfg_bus ();

  gyro_heading_integrator dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_bus),
    .result (result_bus),
    .cfg    (cfg_bus)
  );

  // --------------------------------------------------------------------------
  // Model state. It mirrors the block's registers and heading state and moves
  // only when a request or a register write is accepted on the bus.
  // --------------------------------------------------------------------------
  logic [DZ_W-1:0]     dz_q;
  logic [SCALE_W-1:0]  scale_q;
  logic [CALN_W-1:0]   caln_q;
  longint unsigned     hdg;
  logic [TS_W-1:0]     last_ms;
  logic                ms_seen;
  logic [BIAS_W-1:0]   bias_q;
  logic [CALSUM_W-1:0] cal_acc;
  logic [CALN_W-1:0]   cal_cnt;

  outcome_t readings_due [$];   // results owed by the block, oldest first
  int       mismatches;
  bit       rush;               // when set, neither side idles
  logic [TS_W-1:0] clock_ms;    // running time base for random updates
  step_t    plan [PLAN_LEN];

  // Heading change for one integrating update: |rate| * dt / (16 * scale)
  // degrees, kept as whole degrees modulo a turn plus a truncated fraction.
  // A scale of zero divides as if it were one.
  function automatic longint unsigned turn_increment(longint unsigned mag,
                                                     longint unsigned dt);
    longint unsigned den, num, whole, rem_part, frac;
    den = (scale_q != 0) ? scale_q : 1;
    den = den * 16;
    num = mag * dt;
    whole = num / den;
    rem_part = num % den;
    frac = (rem_part << FRAC_BITS) / den;
    return (((whole % 360) << FRAC_BITS) + frac) % TURN;
  endfunction

  // Advances the model by one accepted item and returns the result it owes.
  function automatic outcome_t track_heading(logic [OPCODE_W-1:0] op,
                                             logic [SAMPLE_W-1:0] sample,
                                             logic [TS_W-1:0] ts,
                                             logic [HEAD_W-1:0] angle);
    outcome_t        res;
    longint          da;
    longint unsigned mag, inc, n, acc;
    logic [TS_W-1:0] dt;
    res.done = 1'b0;
    case (op)
      OP_UPDATE: begin
        if (!ms_seen) begin
          // The very first update only gives the time base.
          ms_seen = 1'b1;
        end else begin
          dt = ts - last_ms;
          da = longint'({sample, 4'b0000}) - longint'(bias_q);
          mag = (da < 0) ? -da : da;
          // A rate inside the deadzone leaves the heading alone, but the
          // timestamp is still taken below.
          if (mag > dz_q) begin
            inc = turn_increment(mag, dt);
            if (da >= 0) hdg = (hdg + inc) % TURN;
            else hdg = (hdg + TURN - inc) % TURN;
          end
        end
        last_ms = ts;
      end
      OP_CAL: begin
        n = (caln_q != 0) ? caln_q : 1;
        cal_acc = cal_acc + sample;
        cal_cnt = cal_cnt + 1'b1;
        // The count compares with >=, so lowering the register below the
        // progress made completes the average on the next sample.
        if (cal_cnt >= n) begin
          acc = cal_acc;
          bias_q = BIAS_W'((acc << 4) / n);
          cal_acc = '0;
          cal_cnt = '0;
          res.done = 1'b1;
        end
      end
      OP_SET_ANGLE: hdg = longint'(angle) % TURN;
      default: ;
    endcase
    res.heading = HEAD_W'(hdg);
    res.bias = bias_q;
    return res;
  endfunction

  function automatic step_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                    logic [CFG_DATA_W-1:0] val);
    step_t s;
    s = '0;
    s.is_reg = 1'b1;
    s.idx = idx;
    s.val = val;
    return s;
  endfunction

  function automatic step_t op_row(logic [OPCODE_W-1:0] op, logic [SAMPLE_W-1:0] sample,
                                   logic [TS_W-1:0] ts, logic [HEAD_W-1:0] angle);
    step_t s;
    s = '0;
    s.op = op;
    s.sample = sample;
    s.ts = ts;
    s.angle = angle;
    return s;
  endfunction

  function automatic step_t known_row(logic [OPCODE_W-1:0] op, logic [SAMPLE_W-1:0] sample,
                                      logic [TS_W-1:0] ts, logic [HEAD_W-1:0] angle,
                                      logic [HEAD_W-1:0] heading, logic [BIAS_W-1:0] bias,
                                      logic done);
    step_t s;
    s = op_row(op, sample, ts, angle);
    s.known = 1'b1;
    s.want.heading = heading;
    s.want.bias = bias;
    s.want.done = done;
    return s;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Request side. Every driven value changes only with a nonblocking
  // assignment right after a rising edge, and ready is read as it stood at
  // that edge. Valid stays high between back-to-back requests.
  // --------------------------------------------------------------------------
  task automatic push_item(input logic [OPCODE_W-1:0] op, input logic [SAMPLE_W-1:0] sample,
                           input logic [TS_W-1:0] ts, input logic [HEAD_W-1:0] angle,
                           input logic known, input outcome_t want);
    int       gap;
    outcome_t got;
    gap = rush ? 0 : $urandom_range(0, 19);
    cfg_bus.valid <= 1'b0;
    if (gap != 0) begin
      item_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_bus.valid     <= 1'b1;
    item_bus.opcode    <= op;
    item_bus.sample    <= sample;
    item_bus.timestamp <= ts;
    item_bus.new_angle <= angle;
    do @(posedge clk); while (!item_bus.ready);
    got = track_heading(op, sample, ts, angle);
    readings_due.push_back(known ? want : got);
  endtask

  // Holds off new requests until every owed result has been taken. The block
  // is idle afterwards, which is when registers may be written. A write left
  // pending from before is withdrawn so that it is not taken twice.
  task automatic settle();
    item_bus.valid <= 1'b0;
    cfg_bus.valid  <= 1'b0;
    do @(posedge clk); while (readings_due.size() != 0);
  endtask

  // Valid is left high so that writes can follow each other without a gap;
  // the next item request or the next settle lowers it.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_DEADZONE:    dz_q = val;
      CFG_SCALE:       scale_q = val;
      CFG_CAL_SAMPLES: caln_q = val[CALN_W-1:0];
      default: ;
    endcase
  endtask

  // Register settings for one random phase. The first two phases take the
  // low and high extremes; the rest lean toward values that let calibration
  // finish often and let rates clear the deadzone.
  task automatic retune(input int p);
    logic [DZ_W-1:0]    dz;
    logic [SCALE_W-1:0] sc;
    logic [CALN_W-1:0]  cn;
    int r;
    if (p == 0) begin
      dz = '0;
      sc = 16'd1;
      cn = 15'd1;
    end else if (p == 1) begin
      dz = '1;
      sc = '1;
      cn = '1;
    end else begin
      r = $urandom_range(0, 99);
      dz = (r < 60) ? DZ_W'($urandom_range(0, 200)) :
           (r < 80) ? DEADZONE_RESET : DZ_W'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      sc = (r < 40) ? SCALE_W'($urandom_range(1, 65535)) : (r < 60) ? SCALE_RESET :
           (r < 85) ? SCALE_W'($urandom_range(1, 40)) : 16'd0;
      r = $urandom_range(0, 99);
      cn = (r < 70) ? CALN_W'($urandom_range(1, 12)) : (r < 85) ? CAL_SAMPLES_RESET :
           (r < 95) ? CALN_W'($urandom_range(1, 400)) : 15'd0;
    end
    write_register(CFG_DEADZONE, dz);
    write_register(CFG_SCALE, sc);
    // The top data bit lies above the count register and must be dropped.
    write_register(CFG_CAL_SAMPLES, {1'($urandom_range(0, 1)), cn});
    if ($urandom_range(0, 2) == 0) write_register(CFG_SPARE, 16'($urandom));
  endtask

  // One random item request. Updates walk forward in time mostly in small
  // steps, with the odd large jump and the odd step backward so that dt
  // wraps. Half of the samples sit near the current bias so that the
  // deadzone edge is hit often.
  task automatic random_request();
    logic [OPCODE_W-1:0] op;
    logic [SAMPLE_W-1:0] sample;
    logic [TS_W-1:0]     ts;
    logic [HEAD_W-1:0]   angle;
    int r, near;
    r = $urandom_range(0, 99);
    op = (r < 55) ? OP_UPDATE : (r < 80) ? OP_CAL : (r < 93) ? OP_SET_ANGLE : OP_UNUSED;
    if ($urandom_range(0, 1) == 0) begin
      near = int'(bias_q >> 4) + int'($urandom_range(0, 20)) - 10;
      sample = (near < 0) ? '0 : (near > 4095) ? '1 : SAMPLE_W'(near);
    end else begin
      sample = SAMPLE_W'($urandom_range(0, 4095));
    end
    r = $urandom_range(0, 99);
    if (op != OP_UPDATE) ts = $urandom;
    else if (r < 80) ts = clock_ms + $urandom_range(0, 50);
    else if (r < 90) ts = clock_ms + $urandom_range(0, 5000);
    else if (r < 97) ts = $urandom;
    else ts = clock_ms - $urandom_range(1, 10);
    if (op == OP_UPDATE) clock_ms = ts;
    angle = ($urandom_range(0, 4) != 0) ? HEAD_W'($urandom_range(0, 32'(TURN - 1)))
                                        : HEAD_W'($urandom);
    push_item(op, sample, ts, angle, 1'b0, '0);
  endtask

  // --------------------------------------------------------------------------
  // Result side: stalls a random number of cycles before each result, then
  // compares what arrives with the oldest owed result.
  // --------------------------------------------------------------------------
  initial begin
    int       stall;
    outcome_t want;
    result_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = rush ? 0 : $urandom_range(0, 19);
      if (stall != 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_bus.ready <= 1'b1;
      do @(posedge clk); while (!result_bus.valid);
      if (readings_due.size() == 0) begin
        flag_mismatch($sformatf("result with no request outstanding, heading %0d",
                                result_bus.heading));
      end else begin
        want = readings_due.pop_front();
        if (result_bus.heading !== want.heading)
          flag_mismatch($sformatf("heading %0d, expected %0d",
                                  result_bus.heading, want.heading));
        if (result_bus.bias_now !== want.bias)
          flag_mismatch($sformatf("bias_now %0d, expected %0d",
                                  result_bus.bias_now, want.bias));
        if (result_bus.cal_done !== want.done)
          flag_mismatch($sformatf("cal_done %0b, expected %0b",
                                  result_bus.cal_done, want.done));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run.
  // --------------------------------------------------------------------------
  initial begin
    item_bus.valid     <= 1'b0;
    item_bus.opcode    <= OP_UPDATE;
    item_bus.sample    <= '0;
    item_bus.timestamp <= '0;
    item_bus.new_angle <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= CFG_DEADZONE;
    cfg_bus.data       <= '0;

    dz_q     = DEADZONE_RESET;
    scale_q  = SCALE_RESET;
    caln_q   = CAL_SAMPLES_RESET;
    hdg      = 0;
    last_ms  = '0;
    ms_seen  = 1'b0;
    bias_q   = BIAS_RESET;
    cal_acc  = '0;
    cal_cnt  = '0;
    mismatches = 0;
    rush     = 1'b0;
    clock_ms = '0;

    // Directed table. The opening rows run at the reset settings. The first
    // update only takes the time base; set-angle values at and past a full
    // turn wrap; the unused opcode reports the state untouched. A count of
    // zero (reached through the masked top data bit) averages single samples,
    // and lowering the count below the progress made closes the average at
    // once: 1000 + 2000 + 3000 times 16 overflows the bias and keeps the low
    // 16 bits. The update rows then straddle the deadzone edge with the bias
    // at 1904.0, wrap dt across zero, and run with a scale of zero and with
    // the deadzone and scale at their maximum.
    plan = '{
      known_row(OP_UPDATE,    12'd0,    32'hFFFF_FFF0, 25'd0,         25'd0,        16'd29917, 1'b0),
      known_row(OP_SET_ANGLE, 12'd0,    32'd0,         25'h1FF_FFFF,  25'd9961471,  16'd29917, 1'b0),
      known_row(OP_SET_ANGLE, 12'd0,    32'd0,         25'd23592959,  25'd23592959, 16'd29917, 1'b0),
      known_row(OP_SET_ANGLE, 12'd0,    32'd0,         25'd23592960,  25'd0,        16'd29917, 1'b0),
      known_row(OP_UNUSED,    12'hFFF,  32'hFFFF_FFFF, 25'h1FF_FFFF,  25'd0,        16'd29917, 1'b0),
      reg_row(CFG_CAL_SAMPLES, 16'h8000),
      known_row(OP_CAL,       12'd4095, 32'd0,         25'd0,         25'd0,        16'd65520, 1'b1),
      known_row(OP_CAL,       12'd0,    32'd0,         25'd0,         25'd0,        16'd0,     1'b1),
      reg_row(CFG_CAL_SAMPLES, 16'd3),
      known_row(OP_CAL,       12'd1000, 32'd0,         25'd0,         25'd0,        16'd0,     1'b0),
      known_row(OP_CAL,       12'd2000, 32'd0,         25'd0,         25'd0,        16'd0,     1'b0),
      reg_row(CFG_CAL_SAMPLES, 16'd1),
      known_row(OP_CAL,       12'd3000, 32'd0,         25'd0,         25'd0,        16'd30464, 1'b1),
      op_row(OP_UPDATE,    12'd4095, 32'h0000_0010, 25'd0),
      op_row(OP_UPDATE,    12'd0,    32'h0000_1010, 25'd0),
      op_row(OP_UPDATE,    12'd1904, 32'h0000_2000, 25'd0),
      op_row(OP_UPDATE,    12'd1907, 32'h0000_2001, 25'd0),
      op_row(OP_UPDATE,    12'd1908, 32'hFFFF_FFFF, 25'd0),
      reg_row(CFG_SCALE,    16'd0),
      reg_row(CFG_DEADZONE, 16'd0),
      op_row(OP_UPDATE,    12'd4095, 32'h7FFF_FFFF, 25'd0),
      op_row(OP_UPDATE,    12'd0,    32'h0000_0000, 25'd0),
      reg_row(CFG_SCALE,    16'hFFFF),
      reg_row(CFG_DEADZONE, 16'hFFFF),
      reg_row(CFG_SPARE,    16'h5A5A),
      op_row(OP_UPDATE,    12'd4095, 32'd12345,     25'd0),
      op_row(OP_SET_ANGLE, 12'd0,    32'd0,         25'h0AB_CDEF),
      op_row(OP_CAL,       12'd2048, 32'd0,         25'd0)
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_register(plan[i].idx, plan[i].val);
      end else begin
        push_item(plan[i].op, plan[i].sample, plan[i].ts, plan[i].angle,
                  plan[i].known, plan[i].want);
      end
    end

    // Random phases. Each one starts from an idle block with new settings;
    // every third phase runs with no idling on either side. Now and then the
    // request side also holds off mid-phase until all results are in.
    for (int p = 0; p < PHASES; p++) begin
      settle();
      rush = (p % 3 == 2);
      retune(p);
      clock_ms = last_ms;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 149) == 0) settle();
        random_request();
      end
    end

    // Drain, then allow more than one slow update for any stray result to
    // show up.
    settle();
    repeat (200) @(posedge clk);
    if (mismatches == 0) begin
      $display("gyro_heading_integrator_tb: PASS");
    end else begin
      $display("gyro_heading_integrator_tb: FAIL");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #5ms;
    $display("gyro_heading_integrator_tb: FAIL");
    $finish;
  end

endmodule

/* gyro_heading_integrator.f */
+incdir+rtl
rtl/ghi_pkg.sv
rtl/ghi_if.sv
rtl/ghi_mul.sv
rtl/ghi_div.sv
rtl/gyro_heading_integrator.sv
dv/gyro_heading_integrator_tb.sv
